// File: rtl/core/point_table_nearest_and_radius_query_assert.svh
// ----------------------------------------------------------------------------
// Point table assertion macros
// Clocked property checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef POINT_TABLE_NEAREST_AND_RADIUS_QUERY_ASSERT_SVH
`define POINT_TABLE_NEAREST_AND_RADIUS_QUERY_ASSERT_SVH
`ifndef SYNTH
// Checked property, switched off while reset is high.
`define PTNRQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds across reset.
`define PTNRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTNRQ_ASSERT(lbl, clk, rst, prop, msg)
`define PTNRQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/ptnrq_pkg.sv
// ----------------------------------------------------------------------------
// Point table package
// Widths, command and status codes, and the types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptnrq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CNT_W     = 7;
  localparam int CRD_W     = 24;
  localparam int KIND_W    = 4;
  localparam int RAD_W     = 23;
  localparam int SQ_W      = 2 * CRD_W;
  localparam int DST_W     = 2 * (CRD_W + 1);
  localparam int RSQ_W     = 2 * RAD_W;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_NEAREST = 2'd1,
    CMD_KIND    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [CRD_W-1:0]  z;
    logic [KIND_W-1:0] kind;
    logic              shelter;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted word
    logic single;  // perform an insert or clear and write its result
    logic issue;   // read one entry into the distance pipeline
    logic finish;  // write the closing result of a query
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             out_free;
    logic             pipe_empty;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/ptnrq_dp.sv
// ----------------------------------------------------------------------------
// Point table datapath
// Entry memory, distance pipeline, candidate tracking and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_table_nearest_and_radius_query_assert.svh"

module ptnrq_dp
  import ptnrq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [CNT_W-1:0]         cfg_data,
  input  logic [1:0]               cmd,
  input  logic signed [CRD_W-1:0]  pos_x,
  input  logic signed [CRD_W-1:0]  pos_y,
  input  logic signed [CRD_W-1:0]  pos_z,
  input  logic [KIND_W-1:0]        kind,
  input  logic                     is_shelter,
  input  logic [RAD_W-1:0]         radius,
  input  ctl_t                     ctl,
  input  logic [IDX_W-1:0]         rd_addr,
  output stat_t                    stat,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [1:0]               status,
  output logic                     found,
  output logic signed [CRD_W-1:0]  out_x,
  output logic signed [CRD_W-1:0]  out_y,
  output logic signed [CRD_W-1:0]  out_z,
  output logic [KIND_W-1:0]        out_kind,
  output logic                     out_shelter,
  output logic [CNT_W-1:0]         entry_count,
  output logic                     last
);

  entry_t mem [DEPTH];

  logic [CNT_W-1:0]  stored_count, stored_count_next;
  logic [CNT_W-1:0]  max_entries;

  logic [1:0]        q_cmd;
  entry_t            q_ent;
  logic [RSQ_W-1:0]  rsq;
  logic [RSQ_W-1:0]  rad_ext, rad_sq;

  logic              v1, v2, v3, v4;
  entry_t            e1, e2, e3, e4;
  logic signed [CRD_W:0]   dx, dy, dz;
  logic signed [DST_W-1:0] px, py, pz;
  logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
  logic [DST_W-1:0]  d4;
  logic [DST_W-1:0]  best;

  logic              cand_v;
  entry_t            cand;

  logic adv, full, near_hit, kind_hit, push, emit;

  assign rad_ext = RSQ_W'(radius);
  assign rad_sq  = rad_ext * rad_ext;

  assign adv  = !out_valid || !out_stall;
  assign full = (stored_count >= max_entries) || (stored_count >= CNT_W'(DEPTH));

  assign px = DST_W'(dx) * DST_W'(dx);
  assign py = DST_W'(dy) * DST_W'(dy);
  assign pz = DST_W'(dz) * DST_W'(dz);

  assign near_hit = v4 && (q_cmd == CMD_NEAREST) && e4.shelter && (d4 < best);
  assign kind_hit = v4 && (q_cmd == CMD_KIND) && (e4.kind == q_ent.kind) &&
                    (d4 <= DST_W'(rsq));
  // A new hit pushes the previous one out; only the final hit carries last.
  assign push     = adv && kind_hit && cand_v;
  assign emit     = ctl.single || ctl.finish || push;

  always_comb begin
    stored_count_next = stored_count;
    if (ctl.single) begin
      if (q_cmd == CMD_CLEAR) begin
        stored_count_next = '0;
      end else if (q_cmd == CMD_INSERT && !full) begin
        stored_count_next = stored_count + CNT_W'(1);
      end
    end
  end

  assign stat.count      = stored_count;
  assign stat.out_free   = adv;
  assign stat.pipe_empty = !(v1 || v2 || v3 || v4);

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      max_entries  <= MAX_ENTRIES_RST;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      cand_v       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      stored_count <= stored_count_next;
      if (cfg_valid) begin
        max_entries <= cfg_data;
      end
      if (adv) begin
        v1 <= ctl.issue;
        v2 <= v1;
        v3 <= v2;
        v4 <= v3;
        if (near_hit || kind_hit) begin
          cand_v <= 1'b1;
        end
      end
      if (ctl.load) begin
        cand_v <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Entry memory: one write port for inserts, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.single && q_cmd == CMD_INSERT && !full) begin
      mem[stored_count[IDX_W-1:0]] <= q_ent;
    end
    if (adv && ctl.issue) begin
      e1 <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_cmd         <= cmd;
      q_ent.x       <= pos_x;
      q_ent.y       <= pos_y;
      q_ent.z       <= pos_z;
      q_ent.kind    <= kind;
      q_ent.shelter <= is_shelter;
      rsq           <= rad_sq;
      best          <= DST_W'(rad_sq);
    end
    if (adv) begin
      e2   <= e1;
      dx   <= {e1.x[CRD_W-1], e1.x} - {q_ent.x[CRD_W-1], q_ent.x};
      dy   <= {e1.y[CRD_W-1], e1.y} - {q_ent.y[CRD_W-1], q_ent.y};
      dz   <= {e1.z[CRD_W-1], e1.z} - {q_ent.z[CRD_W-1], q_ent.z};
      e3   <= e2;
      sq_x <= px[SQ_W-1:0];
      sq_y <= py[SQ_W-1:0];
      sq_z <= pz[SQ_W-1:0];
      e4   <= e3;
      d4   <= DST_W'(sq_x) + DST_W'(sq_y) + DST_W'(sq_z);
      if (near_hit) begin
        best <= d4;
        cand <= e4;
      end
      if (kind_hit) begin
        cand <= e4;
      end
    end

    if (ctl.single) begin
      status      <= (q_cmd == CMD_INSERT && full) ? ST_FULL : ST_OK;
      found       <= 1'b0;
      out_x       <= '0;
      out_y       <= '0;
      out_z       <= '0;
      out_kind    <= '0;
      out_shelter <= 1'b0;
      entry_count <= stored_count_next;
      last        <= 1'b1;
    end else if (ctl.finish || push) begin
      status      <= cand_v ? ST_OK : ST_NONE;
      found       <= cand_v;
      out_x       <= cand_v ? cand.x : '0;
      out_y       <= cand_v ? cand.y : '0;
      out_z       <= cand_v ? cand.z : '0;
      out_kind    <= cand_v ? cand.kind : '0;
      out_shelter <= cand_v && cand.shelter;
      entry_count <= stored_count;
      last        <= ctl.finish;
    end
  end

  `PTNRQ_ASSERT(a_count_bound, clk, rst, stored_count <= CNT_W'(DEPTH), "entry count above depth")
  `PTNRQ_ASSERT(a_insert_grows, clk, rst, (ctl.single && q_cmd == CMD_INSERT && !full) |=> (stored_count == $past(stored_count) + CNT_W'(1)), "accepted insert did not add one entry")
  `PTNRQ_ASSERT(a_found_ok, clk, rst, (out_valid && found) |-> (status == ST_OK), "found result without ok status")

endmodule

`default_nettype wire

// File: rtl/core/ptnrq_ctrl.sv
// ----------------------------------------------------------------------------
// Point table controller
// Accepts words, sequences inserts and clears, and walks the table for queries.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_table_nearest_and_radius_query_assert.svh"

module ptnrq_ctrl
  import ptnrq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       cmd,
  output logic             in_stall,
  input  stat_t            stat,
  output ctl_t             ctl,
  output logic [IDX_W-1:0] rd_addr
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SINGLE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] scan_idx, scan_idx_next;
  logic             accept, last_issue;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign last_issue = (CNT_W'(scan_idx) + CNT_W'(1)) == stat.count;
  assign rd_addr    = scan_idx;

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    ctl           = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.load      = 1'b1;
          scan_idx_next = '0;
          if (cmd inside {CMD_INSERT, CMD_CLEAR}) begin
            state_next = S_SINGLE;
          end else if (stat.count == '0) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          ctl.single = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.out_free) begin
          ctl.issue = 1'b1;
          if (last_issue) begin
            state_next = S_FINISH;
          end else begin
            scan_idx_next = scan_idx + IDX_W'(1);
          end
        end
      end
      S_FINISH: begin
        if (stat.pipe_empty && stat.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_idx <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
    end
  end

  `PTNRQ_ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> !in_stall, "block not ready after reset")
  `PTNRQ_ASSERT(a_busy_after_accept, clk, rst, (in_valid && !in_stall) |=> in_stall, "second word taken while busy")
  `PTNRQ_ASSERT(a_issue_in_range, clk, rst, ctl.issue |-> (CNT_W'(rd_addr) < stat.count), "scan read beyond stored entries")

endmodule

`default_nettype wire

// File: rtl/core/point_table_nearest_and_radius_query.sv
// ----------------------------------------------------------------------------
// Point table with nearest and radius queries
// Top level: controller, datapath and the configuration port.
// ----------------------------------------------------------------------------
// The block stores up to DEPTH points, each with signed 24-bit coordinates, a
// 4-bit kind and a shelter flag, and answers one command word at a time. An
// insert or a clear waits in the single state for a free output register,
// then writes its result word. A query walks the stored entries in order,
// one entry per cycle through a registered memory read and a three-stage
// squared-distance pipeline, while a stalled output holds the walk. The
// nearest-shelter query gives one word; the kind-in-radius query gives one
// word per hit with last on the final hit, or a single nothing-found word. A
// new command word is taken while the previous result still waits in the
// output register. The capacity register may be written at any time the
// block is idle; its write is always ready.
`default_nettype none

module point_table_nearest_and_radius_query
  import ptnrq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // Capacity register write.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_data,
  // Command word.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic signed [CRD_W-1:0]  pos_x,
  input  logic signed [CRD_W-1:0]  pos_y,
  input  logic signed [CRD_W-1:0]  pos_z,
  input  logic [KIND_W-1:0]        kind,
  input  logic                     is_shelter,
  input  logic [RAD_W-1:0]         radius,
  // Result word.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic                     found,
  output logic signed [CRD_W-1:0]  out_x,
  output logic signed [CRD_W-1:0]  out_y,
  output logic signed [CRD_W-1:0]  out_z,
  output logic [KIND_W-1:0]        out_kind,
  output logic                     out_shelter,
  output logic [CNT_W-1:0]         entry_count,
  output logic                     last
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ctl_t             ctl;
  stat_t            stat;
  logic [IDX_W-1:0] rd_addr;

  // The register is a plain flop, so a write never waits.
  assign cfg_ready = 1'b1;

  ptnrq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl),
    .rd_addr  (rd_addr)
  );

  ptnrq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .kind        (kind),
    .is_shelter  (is_shelter),
    .radius      (radius),
    .ctl         (ctl),
    .rd_addr     (rd_addr),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .found       (found),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_kind    (out_kind),
    .out_shelter (out_shelter),
    .entry_count (entry_count),
    .last        (last)
  );

endmodule

`default_nettype wire

// File: dv/point_table_nearest_and_radius_query_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point table nearest and radius query testbench
// Drives command words through the block and checks each result word
// against a table model that lives in this file.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the point table: the stored entries, the
// entry count and the capacity register. Each command word is run through
// that copy at the edge where the block accepts it. The words it is expected
// to produce are queued, and every result word is compared against the front
// of that queue. A short directed pass covers the empty table, the coordinate
// extremes, the strict and inclusive radius edges and ties. Random traffic
// follows under several capacity settings, with both sides pausing at random.
// Queries are often centred right next to a stored point, so that hits and
// radius boundaries come up often. One stretch holds the result side off
// long enough for the block to back up and stall its command input.
// ----------------------------------------------------------------------------

module point_table_nearest_and_radius_query_tb;
  import ptnrq_pkg::*;

  localparam int     TABLE_DEPTH    = DEPTH_DEF;
  localparam longint CRD_MAX        = 64'sd8388607;
  localparam longint CRD_MIN        = -64'sd8388608;
  localparam longint RAD_MAX        = 64'sd8388607;
  // SETTLE_CYCLES lets the block settle after the last owed word is collected
  // and before the capacity register changes.
  localparam int     SETTLE_CYCLES  = 8;
  localparam int     TAIL_CYCLES    = 100;
  localparam int     HOLD_CYCLES    = 300;
  // The longest quiet stretch in a correct run is the long hold on the
  // result side. A full-table query with a stall on each of its words stays
  // well below that.
  localparam int     WATCHDOG_LIMIT = 4000;

  // One command word as the sender offers it.
  typedef struct packed {
    cmd_t                    op;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
    logic [KIND_W-1:0]       kind;
    logic                    shelter;
    logic [RAD_W-1:0]        radius;
  } command_word_t;

  // One result word as the block should present it.
  typedef struct packed {
    logic [1:0]              status;
    logic                    found;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
    logic [KIND_W-1:0]       kind;
    logic                    shelter;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } answer_word_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CNT_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              cmd;
  logic signed [CRD_W-1:0] pos_x;
  logic signed [CRD_W-1:0] pos_y;
  logic signed [CRD_W-1:0] pos_z;
  logic [KIND_W-1:0]       kind;
  logic                    is_shelter;
  logic [RAD_W-1:0]        radius;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              status;
  logic                    found;
  logic signed [CRD_W-1:0] out_x;
  logic signed [CRD_W-1:0] out_y;
  logic signed [CRD_W-1:0] out_z;
  logic [KIND_W-1:0]       out_kind;
  logic                    out_shelter;
  logic [CNT_W-1:0]        entry_count;
  logic                    last;

  // Table model: the entries, how many are stored, and the capacity limit.
  logic signed [CRD_W-1:0] tbl_x [TABLE_DEPTH];
  logic signed [CRD_W-1:0] tbl_y [TABLE_DEPTH];
  logic signed [CRD_W-1:0] tbl_z [TABLE_DEPTH];
  logic [KIND_W-1:0]       tbl_kind [TABLE_DEPTH];
  logic                    tbl_shelter [TABLE_DEPTH];
  int                      tbl_count = 0;
  int                      cap_limit = int'(MAX_ENTRIES_RST);

  // Result words still owed by the block, oldest first.
  answer_word_t answers_due[$];

  int fault_count    = 0;
  int words_sent     = 0;
  int words_seen     = 0;
  int cfg_writes     = 0;
  int refusals       = 0;
  int longest_answer = 0;
  int idle_cycles    = 0;

  // Set by the tests: steady turns off random pauses on both sides, and
  // hold_cycles asks the result side for one long hold-off.
  bit steady      = 1'b0;
  int hold_cycles = 0;

  point_table_nearest_and_radius_query #(
    .DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .kind       (kind),
    .is_shelter (is_shelter),
    .radius     (radius),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .found      (found),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_kind   (out_kind),
    .out_shelter(out_shelter),
    .entry_count(entry_count),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------

  // Builds a result word; idx below zero means no entry is reported and the
  // entry fields stay zero.
  function automatic answer_word_t entry_answer(logic [1:0] st, int idx, logic fin);
    answer_word_t a;
    a        = '0;
    a.status = st;
    a.count  = CNT_W'(tbl_count);
    a.last   = fin;
    if (idx >= 0) begin
      a.found   = 1'b1;
      a.x       = tbl_x[idx];
      a.y       = tbl_y[idx];
      a.z       = tbl_z[idx];
      a.kind    = tbl_kind[idx];
      a.shelter = tbl_shelter[idx];
    end
    return a;
  endfunction

  // Exact squared distance from stored entry idx to the query centre. It stays
  // below 2^50, so a longint holds it without loss.
  function automatic longint span_sq(int idx, command_word_t w);
    longint dx, dy, dz;
    dx = longint'(tbl_x[idx]) - longint'($signed(w.x));
    dy = longint'(tbl_y[idx]) - longint'($signed(w.y));
    dz = longint'(tbl_z[idx]) - longint'($signed(w.z));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Applies one accepted command word to the table model and queues the
  // result words it should produce.
  function automatic void answer_command(command_word_t w);
    longint rsq, best, d;
    int     hit, hits;
    rsq = longint'(w.radius) * longint'(w.radius);
    case (w.op)
      CMD_INSERT: begin
        // The table refuses once the count reaches the smaller of the
        // register and the table depth; a lowered limit keeps the entries.
        if (tbl_count >= cap_limit || tbl_count >= TABLE_DEPTH) begin
          refusals++;
          answers_due.push_back(entry_answer(ST_FULL, -1, 1'b1));
        end else begin
          tbl_x[tbl_count]       = w.x;
          tbl_y[tbl_count]       = w.y;
          tbl_z[tbl_count]       = w.z;
          tbl_kind[tbl_count]    = w.kind;
          tbl_shelter[tbl_count] = w.shelter;
          tbl_count++;
          answers_due.push_back(entry_answer(ST_OK, -1, 1'b1));
        end
      end
      CMD_NEAREST: begin
        // Strictly inside the radius, and a later entry must be strictly
        // closer to win, so the earliest of equal distances is reported.
        best = rsq;
        hit  = -1;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_shelter[i]) begin
            d = span_sq(i, w);
            if (d < best) begin
              best = d;
              hit  = i;
            end
          end
        end
        answers_due.push_back(entry_answer((hit >= 0) ? ST_OK : ST_NONE, hit, 1'b1));
      end
      CMD_KIND: begin
        // Inclusive radius; one word per hit in stored order, last on the
        // final hit, or a single nothing-found word.
        hits = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_kind[i] == w.kind && span_sq(i, w) <= rsq) begin
            answers_due.push_back(entry_answer(ST_OK, i, 1'b0));
            hits++;
          end
        end
        if (hits == 0) begin
          answers_due.push_back(entry_answer(ST_NONE, -1, 1'b1));
        end else begin
          answers_due[answers_due.size() - 1].last = 1'b1;
        end
        if (hits > longest_answer) begin
          longest_answer = hits;
        end
      end
      default: begin
        tbl_count = 0;
        answers_due.push_back(entry_answer(ST_OK, -1, 1'b1));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic command_word_t word_of(cmd_t op, longint x, longint y, longint z,
                                            int k, bit shel, longint rad);
    command_word_t w;
    w.op      = op;
    w.x       = CRD_W'(x);
    w.y       = CRD_W'(y);
    w.z       = CRD_W'(z);
    w.kind    = KIND_W'(k);
    w.shelter = shel;
    w.radius  = RAD_W'(rad);
    return w;
  endfunction

  // Mostly a small box around the origin so that points crowd together, with
  // the odd full-range value and the two extremes.
  function automatic logic signed [CRD_W-1:0] draw_coord();
    case ($urandom_range(0, 9))
      0:       return CRD_W'($urandom);
      1:       return $urandom_range(0, 1) ? CRD_W'(CRD_MAX) : CRD_W'(CRD_MIN);
      default: return CRD_W'(longint'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] draw_radius();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RAD_W'(RAD_MAX);
      2:       return RAD_W'($urandom);
      default: return RAD_W'($urandom_range(0, 4000));
    endcase
  endfunction

  // Random command word. Queries are often centred one axis step away from
  // a stored point, with the radius equal to that step or one off from it,
  // so the strict and inclusive boundaries are hit again and again.
  function automatic command_word_t draw_word(int insert_pct, int clear_pct);
    command_word_t w;
    int            roll, j, d, axis, r;
    longint        pt[3];
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) begin
      w.op = CMD_INSERT;
    end else if (roll < insert_pct + clear_pct) begin
      w.op = CMD_CLEAR;
    end else if ($urandom_range(0, 99) < 45) begin
      w.op = CMD_NEAREST;
    end else begin
      w.op = CMD_KIND;
    end
    w.x       = draw_coord();
    w.y       = draw_coord();
    w.z       = draw_coord();
    w.kind    = ($urandom_range(0, 4) == 0) ? KIND_W'($urandom) : KIND_W'($urandom_range(0, 3));
    w.shelter = 1'($urandom_range(0, 1));
    w.radius  = draw_radius();
    if ((w.op == CMD_NEAREST || w.op == CMD_KIND) && tbl_count > 0 &&
        $urandom_range(0, 9) < 4) begin
      j     = $urandom_range(0, tbl_count - 1);
      pt[0] = longint'(tbl_x[j]);
      pt[1] = longint'(tbl_y[j]);
      pt[2] = longint'(tbl_z[j]);
      axis  = $urandom_range(0, 2);
      d     = $urandom_range(0, 600);
      r     = $urandom_range(0, 2);
      r     = r + d - 1;
      if (r < 0) begin
        r = 0;
      end
      if ($urandom_range(0, 1)) begin
        d = -d;
      end
      // Step the other way when the point sits at the edge of the range.
      if (pt[axis] + d > CRD_MAX || pt[axis] + d < CRD_MIN) begin
        d = -d;
      end
      pt[axis] = pt[axis] + d;
      w.x      = CRD_W'(pt[0]);
      w.y      = CRD_W'(pt[1]);
      w.z      = CRD_W'(pt[2]);
      w.radius = RAD_W'(r);
      if ($urandom_range(0, 9) < 7) begin
        w.kind = tbl_kind[j];
      end
    end
    return w;
  endfunction

  // Offers one command word and returns at the edge where it is accepted.
  // Valid stays high after acceptance; the next call either keeps it high
  // with a new word or drops it for a random gap.
  task automatic send_word(command_word_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= w.op;
    pos_x      <= w.x;
    pos_y      <= w.y;
    pos_z      <= w.z;
    kind       <= w.kind;
    is_shelter <= w.shelter;
    radius     <= w.radius;
    do @(posedge clk); while (!(in_valid && !in_stall));
    answer_command(w);
    words_sent++;
  endtask

  // The capacity register only changes while the block is idle: the command
  // side goes quiet, every owed word is collected, and the block settles.
  task automatic write_capacity(int limit);
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_W'(limit);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_limit = limit;
    cfg_writes++;
  endtask

  task automatic run_mixed_traffic(int words, int insert_pct, int clear_pct);
    repeat (words) send_word(draw_word(insert_pct, clear_pct));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty-table queries, coordinate extremes, ties and both radius edges.
  task automatic test_corner_points();
    send_word(word_of(CMD_KIND, 0, 0, 0, 0, 1'b0, RAD_MAX));
    send_word(word_of(CMD_NEAREST, 0, 0, 0, 0, 1'b1, RAD_MAX));
    send_word(word_of(CMD_INSERT, CRD_MAX, CRD_MAX, CRD_MAX, 15, 1'b1, 0));
    send_word(word_of(CMD_INSERT, CRD_MIN, CRD_MIN, CRD_MIN, 15, 1'b1, RAD_MAX));
    send_word(word_of(CMD_INSERT, 0, 0, 0, 0, 1'b0, 0));
    send_word(word_of(CMD_INSERT, 0, 0, 0, 0, 1'b1, 0));
    send_word(word_of(CMD_INSERT, 0, 0, 0, 0, 1'b1, 0));
    // Two shelters at the same distance: the earlier one must win.
    send_word(word_of(CMD_NEAREST, 10, 0, 0, 0, 1'b0, 100));
    // Distance zero and radius zero: strictly below fails.
    send_word(word_of(CMD_NEAREST, 0, 0, 0, 0, 1'b0, 0));
    send_word(word_of(CMD_NEAREST, 5, 0, 0, 0, 1'b0, 5));
    send_word(word_of(CMD_NEAREST, 5, 0, 0, 0, 1'b0, 6));
    // The same distance is inside for the kind query, giving three hits.
    send_word(word_of(CMD_KIND, 5, 0, 0, 0, 1'b0, 5));
    // The corner points lie beyond even the largest radius from the origin.
    send_word(word_of(CMD_KIND, 0, 0, 0, 15, 1'b0, RAD_MAX));
    send_word(word_of(CMD_NEAREST, CRD_MIN, CRD_MIN, CRD_MIN, 0, 1'b0, RAD_MAX));
    send_word(word_of(CMD_KIND, CRD_MAX, CRD_MAX, CRD_MAX, 15, 1'b0, 0));
    send_word(word_of(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 0));
    send_word(word_of(CMD_KIND, 0, 0, 0, 0, 1'b0, RAD_MAX));
  endtask

  // Zero capacity, a small limit reached, and a limit lowered below the count.
  task automatic test_capacity_limits();
    write_capacity(0);
    send_word(word_of(CMD_INSERT, 1, 2, 3, 1, 1'b1, 0));
    write_capacity(2);
    send_word(word_of(CMD_INSERT, 1, 2, 3, 1, 1'b1, 0));
    send_word(word_of(CMD_INSERT, -4, 5, -6, 1, 1'b0, 0));
    send_word(word_of(CMD_INSERT, 7, 8, 9, 1, 1'b1, 0));
    write_capacity(1);
    send_word(word_of(CMD_INSERT, 7, 8, 9, 1, 1'b1, 0));
    send_word(word_of(CMD_NEAREST, 0, 0, 0, 0, 1'b0, RAD_MAX));
    send_word(word_of(CMD_KIND, 0, 0, 0, 1, 1'b0, 100));
    send_word(word_of(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 0));
  endtask

  // Mostly inserts with no clears, so the table fills to its depth and
  // then refuses, with queries over a growing table mixed in.
  task automatic test_fill_table();
    write_capacity(TABLE_DEPTH);
    run_mixed_traffic(80, 85, 0);
  endtask

  // The result side holds off for a long stretch while commands keep coming
  // back to back, so the block backs up and stalls its command input.
  task automatic test_output_hold();
    steady      = 1'b1;
    hold_cycles = HOLD_CYCLES;
    run_mixed_traffic(16, 10, 0);
    steady = 1'b0;
  endtask

  task automatic test_small_table();
    write_capacity(5);
    run_mixed_traffic(20, 45, 8);
  endtask

  // One-entry table with no pauses on either side.
  task automatic test_back_to_back();
    write_capacity(1);
    steady = 1'b1;
    run_mixed_traffic(16, 40, 15);
    steady = 1'b0;
  endtask

  task automatic test_zero_capacity();
    write_capacity(0);
    run_mixed_traffic(10, 40, 15);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, long hold on request, and the checker
  // --------------------------------------------------------------------------

  initial begin
    int pause;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      pause = steady ? 0 : $urandom_range(0, 3);
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic compare_field(string field, logic signed [63:0] want,
                               logic signed [63:0] got);
    if (got !== want) begin
      fault_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    answer_word_t want;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (answers_due.size() == 0) begin
        fault_count++;
        $display("%0t: result word arrived with none expected", $time);
      end else begin
        want = answers_due.pop_front();
        compare_field("status", 64'(want.status), 64'(status));
        compare_field("found", 64'(want.found), 64'(found));
        compare_field("out_x", 64'(want.x), 64'(out_x));
        compare_field("out_y", 64'(want.y), 64'(out_y));
        compare_field("out_z", 64'(want.z), 64'(out_z));
        compare_field("out_kind", 64'(want.kind), 64'(out_kind));
        compare_field("out_shelter", 64'(want.shelter), 64'(out_shelter));
        compare_field("entry_count", 64'(want.count), 64'(entry_count));
        compare_field("last", 64'(want.last), 64'(last));
      end
    end
  end

  // Ends a run that has stopped moving: no word accepted on any channel for
  // far longer than any correct stretch of quiet.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d result words still owed",
               $time, idle_cycles, answers_due.size());
      $display("** point_table_nearest_and_radius_query: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    cmd        <= CMD_INSERT;
    pos_x      <= '0;
    pos_y      <= '0;
    pos_z      <= '0;
    kind       <= '0;
    is_shelter <= 1'b0;
    radius     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_corner_points();
    test_capacity_limits();
    test_fill_table();
    test_output_hold();
    test_small_table();
    test_back_to_back();
    test_zero_capacity();

    // Collect every owed word, then watch a while longer for strays.
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d command words and checked %0d result words over %0d capacity writes.",
             words_sent, words_seen, cfg_writes);
    $display("Longest kind query answer: %0d words; refused inserts: %0d.",
             longest_answer, refusals);
    if (fault_count == 0 && answers_due.size() == 0) begin
      $display("** point_table_nearest_and_radius_query: PASSED **");
    end else begin
      $display("** point_table_nearest_and_radius_query: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/ptnrq_pkg.sv
rtl/core/ptnrq_dp.sv
rtl/core/ptnrq_ctrl.sv
rtl/core/point_table_nearest_and_radius_query.sv
dv/point_table_nearest_and_radius_query_tb.sv
